FILE: src/lca_pkg.sv
package lca_pkg;

  localparam int NODE_W     = 10;
  localparam int DEPTH_W    = 10;
  // wide enough for any level below the largest LEVELS
  localparam int LVL_W      = 4;
  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 10;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // table access requests from the sequencer
  typedef struct packed {
    logic               dep_we;
    logic [NODE_W-1:0]  dep_wnode;
    logic [DEPTH_W-1:0] dep_wdata;
    logic               dep_re_a;
    logic [NODE_W-1:0]  dep_node_a;
    logic               dep_re_b;
    logic [NODE_W-1:0]  dep_node_b;
    logic               jmp_we;
    logic [LVL_W-1:0]   jmp_wlvl;
    logic [NODE_W-1:0]  jmp_wnode;
    logic [NODE_W-1:0]  jmp_wdata;
    logic               jmp_re_a;
    logic [LVL_W-1:0]   jmp_lvl_a;
    logic [NODE_W-1:0]  jmp_node_a;
    logic               jmp_re_b;
    logic [LVL_W-1:0]   jmp_lvl_b;
    logic [NODE_W-1:0]  jmp_node_b;
  } lca_req_t;

  // registered read data, node 0 reads as zero
  typedef struct packed {
    logic [DEPTH_W-1:0] dep_a;
    logic [DEPTH_W-1:0] dep_b;
    logic [NODE_W-1:0]  jmp_a;
    logic [NODE_W-1:0]  jmp_b;
  } lca_rsp_t;

  function automatic logic [LVL_W-1:0] floor_log2(input logic [DEPTH_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 1; i < DEPTH_W; i++) begin
      if (v[i]) begin
        r = LVL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: src/lca_store.sv
module lca_store import lca_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic     clk_i,
  input  lca_req_t req_i,
  output lca_rsp_t rsp_o
);

  localparam int AW     = $clog2(NODES);
  localparam int JDEPTH = LEVELS * NODES;
  localparam int JW     = (JDEPTH > 1) ? $clog2(JDEPTH) : 1;

  logic [DEPTH_W-1:0] dep_mem [NODES];
  logic [NODE_W-1:0]  jmp_mem [JDEPTH];

  logic [DEPTH_W-1:0] dep_a_q, dep_b_q;
  logic [NODE_W-1:0]  jmp_a_q, jmp_b_q;
  logic               dep_a_zero_q, dep_b_zero_q, jmp_a_zero_q, jmp_b_zero_q;

  function automatic logic [JW-1:0] jaddr(input logic [LVL_W-1:0] lvl,
                                          input logic [NODE_W-1:0] node);
    return JW'(lvl) * JW'(NODES) + JW'(AW'(node));
  endfunction

  always_ff @(posedge clk_i) begin
    if (req_i.dep_we) begin
      dep_mem[AW'(req_i.dep_wnode)] <= req_i.dep_wdata;
    end
    if (req_i.dep_re_a) begin
      dep_a_q      <= dep_mem[AW'(req_i.dep_node_a)];
      dep_a_zero_q <= (req_i.dep_node_a == '0);
    end
    if (req_i.dep_re_b) begin
      dep_b_q      <= dep_mem[AW'(req_i.dep_node_b)];
      dep_b_zero_q <= (req_i.dep_node_b == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.jmp_we) begin
      jmp_mem[jaddr(req_i.jmp_wlvl, req_i.jmp_wnode)] <= req_i.jmp_wdata;
    end
    if (req_i.jmp_re_a) begin
      jmp_a_q      <= jmp_mem[jaddr(req_i.jmp_lvl_a, req_i.jmp_node_a)];
      jmp_a_zero_q <= (req_i.jmp_node_a == '0);
    end
    if (req_i.jmp_re_b) begin
      jmp_b_q      <= jmp_mem[jaddr(req_i.jmp_lvl_b, req_i.jmp_node_b)];
      jmp_b_zero_q <= (req_i.jmp_node_b == '0);
    end
  end

  // node 0 is never written, so its entries need no clearing
  assign rsp_o.dep_a = dep_a_zero_q ? '0 : dep_a_q;
  assign rsp_o.dep_b = dep_b_zero_q ? '0 : dep_b_q;
  assign rsp_o.jmp_a = jmp_a_zero_q ? '0 : jmp_a_q;
  assign rsp_o.jmp_b = jmp_b_zero_q ? '0 : jmp_b_q;

endmodule

FILE: src/lca_seq.sv
module lca_seq import lca_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              cmd_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  output logic              busy_o,
  output logic              valid_o,
  output logic [NODE_W-1:0] ancestor_o,
  output lca_req_t          req_o,
  input  lca_rsp_t          rsp_i
);

  localparam int STEP_W = $clog2(NODES + 1);
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INS0  = 4'd1;
  localparam logic [3:0] S_INS1  = 4'd2;
  localparam logic [3:0] S_INSL  = 4'd3;
  localparam logic [3:0] S_Q0    = 4'd4;
  localparam logic [3:0] S_Q1    = 4'd5;
  localparam logic [3:0] S_LIFT  = 4'd6;
  localparam logic [3:0] S_LIFT2 = 4'd7;
  localparam logic [3:0] S_DESC  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [NODE_W-1:0]  x_q, x_d, y_q, y_d;
  logic [DEPTH_W-1:0] dy_q, dy_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  logic               valid_q, valid_d;
  logic [NODE_W-1:0]  anc_q, anc_d;
  logic               fwd_q, fwd_d;

  logic [DEPTH_W-1:0] diff;
  logic [LVL_W-1:0]   lift_lvl, top_lvl;
  logic [NODE_W-1:0]  nx, ny;
  logic [NODE_W-1:0]  ins_anc;

  function automatic logic [NODE_W-1:0] fit_node(input logic [NODE_W-1:0] v);
    return (32'(v) < NODES) ? v : '0;
  endfunction

  function automatic logic [LVL_W-1:0] clamp_lvl(input logic [LVL_W-1:0] l);
    return (l > LVL_TOP) ? LVL_TOP : l;
  endfunction

  always_comb begin
    diff     = rsp_i.dep_a - dy_q;
    lift_lvl = clamp_lvl(floor_log2(diff));
    top_lvl  = clamp_lvl(floor_log2(rsp_i.dep_a));
    // descent keeps both nodes below the common ancestor
    nx       = (rsp_i.jmp_a != rsp_i.jmp_b) ? rsp_i.jmp_a : x_q;
    ny       = (rsp_i.jmp_a != rsp_i.jmp_b) ? rsp_i.jmp_b : y_q;
    // the read of the node's own entry clashed with its write: take the new word
    ins_anc  = fwd_q ? x_q : rsp_i.jmp_a;
  end

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    dy_d    = dy_q;
    lvl_d   = lvl_q;
    steps_d = steps_q;
    valid_d = 1'b0;
    anc_d   = anc_q;
    fwd_d   = 1'b0;
    req_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (cmd_i == CMD_QUERY) begin
            x_d     = fit_node(node_a_i);
            y_d     = fit_node(node_b_i);
            state_d = S_Q0;
          end else if (node_a_i != '0 && 32'(node_a_i) < NODES) begin
            x_d     = node_a_i;
            y_d     = fit_node(node_b_i);
            state_d = S_INS0;
          end
        end
      end
      S_INS0: begin
        req_o.jmp_we     = 1'b1;
        req_o.jmp_wlvl   = '0;
        req_o.jmp_wnode  = x_q;
        req_o.jmp_wdata  = y_q;
        req_o.dep_re_a   = 1'b1;
        req_o.dep_node_a = y_q;
        state_d          = S_INS1;
      end
      S_INS1: begin
        req_o.dep_we     = 1'b1;
        req_o.dep_wnode  = x_q;
        req_o.dep_wdata  = rsp_i.dep_a + DEPTH_W'(1);
        req_o.jmp_re_a   = 1'b1;
        req_o.jmp_lvl_a  = '0;
        req_o.jmp_node_a = y_q;
        lvl_d            = LVL_W'(1);
        state_d          = (LEVELS == 1) ? S_IDLE : S_INSL;
      end
      S_INSL: begin
        // level i of the node is level i-1 of its level i-1 ancestor
        req_o.jmp_we    = 1'b1;
        req_o.jmp_wlvl  = lvl_q;
        req_o.jmp_wnode = x_q;
        req_o.jmp_wdata = ins_anc;
        if (lvl_q == LVL_TOP) begin
          state_d = S_IDLE;
        end else begin
          req_o.jmp_re_a   = 1'b1;
          req_o.jmp_lvl_a  = lvl_q;
          req_o.jmp_node_a = ins_anc;
          fwd_d            = (ins_anc == x_q);
          lvl_d            = lvl_q + LVL_W'(1);
        end
      end
      S_Q0: begin
        req_o.dep_re_a   = 1'b1;
        req_o.dep_node_a = x_q;
        req_o.dep_re_b   = 1'b1;
        req_o.dep_node_b = y_q;
        state_d          = S_Q1;
      end
      S_Q1: begin
        req_o.dep_re_a = 1'b1;
        if (rsp_i.dep_a < rsp_i.dep_b) begin
          x_d              = y_q;
          y_d              = x_q;
          dy_d             = rsp_i.dep_a;
          req_o.dep_node_a = y_q;
        end else begin
          dy_d             = rsp_i.dep_b;
          req_o.dep_node_a = x_q;
        end
        steps_d = '0;
        state_d = S_LIFT;
      end
      S_LIFT: begin
        // depth of x is on port a here
        if (rsp_i.dep_a > dy_q && 32'(steps_q) < NODES) begin
          req_o.jmp_re_a   = 1'b1;
          req_o.jmp_lvl_a  = lift_lvl;
          req_o.jmp_node_a = x_q;
          state_d          = S_LIFT2;
        end else if (x_q == y_q) begin
          valid_d = 1'b1;
          anc_d   = x_q;
          state_d = S_IDLE;
        end else begin
          req_o.jmp_re_a   = 1'b1;
          req_o.jmp_lvl_a  = top_lvl;
          req_o.jmp_node_a = x_q;
          req_o.jmp_re_b   = 1'b1;
          req_o.jmp_lvl_b  = top_lvl;
          req_o.jmp_node_b = y_q;
          lvl_d            = top_lvl;
          state_d          = S_DESC;
        end
      end
      S_LIFT2: begin
        x_d              = rsp_i.jmp_a;
        req_o.dep_re_a   = 1'b1;
        req_o.dep_node_a = rsp_i.jmp_a;
        steps_d          = steps_q + STEP_W'(1);
        state_d          = S_LIFT;
      end
      S_DESC: begin
        x_d              = nx;
        y_d              = ny;
        req_o.jmp_re_a   = 1'b1;
        req_o.jmp_node_a = nx;
        if (lvl_q == '0) begin
          req_o.jmp_lvl_a = '0;
          state_d         = S_FIN;
        end else begin
          req_o.jmp_lvl_a  = lvl_q - LVL_W'(1);
          req_o.jmp_re_b   = 1'b1;
          req_o.jmp_lvl_b  = lvl_q - LVL_W'(1);
          req_o.jmp_node_b = ny;
          lvl_d            = lvl_q - LVL_W'(1);
        end
      end
      S_FIN: begin
        valid_d = 1'b1;
        anc_d   = rsp_i.jmp_a;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    dy_q    <= dy_d;
    lvl_q   <= lvl_d;
    steps_q <= steps_d;
    anc_q   <= anc_d;
    fwd_q   <= fwd_d;
  end

  assign busy_o     = (state_q != S_IDLE);
  assign valid_o    = valid_q;
  assign ancestor_o = anc_q;

endmodule

FILE: src/binary_lifting_lca.sv
// Insert: busy while the parent, the depth and each jump level are written, no
// result; an insert of node 0 or of a node out of range is dropped and never
// raises busy. Query: busy while both depths are read, each lifting jump is
// taken and, when a descent is needed, each descent level and the final parent
// are read; the strobe follows in the next cycle. One item at a time. Reset
// clears the sequencer only; tables are not cleared, node 0 reads as zero.
module binary_lifting_lca import lca_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cmd_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  output logic              valid_o,
  output logic [NODE_W-1:0] ancestor_o
);

  lca_req_t req;
  lca_rsp_t rsp;

  lca_seq #(
    .NODES (NODES),
    .LEVELS(LEVELS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cmd_i     (cmd_i),
    .node_a_i  (node_a_i),
    .node_b_i  (node_b_i),
    .busy_o    (busy),
    .valid_o   (valid_o),
    .ancestor_o(ancestor_o),
    .req_o     (req),
    .rsp_i     (rsp)
  );

  lca_store #(
    .NODES (NODES),
    .LEVELS(LEVELS)
  ) u_store (
    .clk_i(clk_i),
    .req_i(req),
    .rsp_o(rsp)
  );

  // a result only appears once the sequencer is back at rest
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_QUERY) |=> (busy && !valid_o))
    else $error("query item not taken up");

  // node 0 entries must stay zero
  a_no_node0_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.dep_we || req.jmp_we) |-> (req.dep_wnode != '0 || !req.dep_we) &&
                                   (req.jmp_wnode != '0 || !req.jmp_we))
    else $error("table write to node 0");

endmodule
